FILE: hdl/ryc_pkg.sv
// ---------------------------------------------------------------------------
// ryc_pkg
// Shared types and fixed constants of the RGB to YUV 4:2:0 converter.
// ---------------------------------------------------------------------------
`default_nettype none

package ryc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PAIRS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PAIRS = 1'd1;

	localparam logic [CFG_DATA_W-1:0] WIDTH_PAIRS_RESET  = 11'd320;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_PAIRS_RESET = 11'd240;

	// coefficients as five-decimal integers, scaled by COEF_SCALE
	localparam longint unsigned COEF_SCALE = 100000;
	localparam longint unsigned Y_R_K = 29900;
	localparam longint unsigned Y_G_K = 58700;
	localparam longint unsigned Y_B_K = 11400;
	localparam longint unsigned U_R_K = 14713;
	localparam longint unsigned U_G_K = 28886;
	localparam longint unsigned U_B_K = 43600;
	localparam longint unsigned V_R_K = 61500;
	localparam longint unsigned V_G_K = 51499;
	localparam longint unsigned V_B_K = 10001;

	localparam int CHROMA_OFFSET = 128;

	// stream widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 48;
	localparam int POS_W      = 11;

	// input pixel, red in the lowest bits
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// sums of two horizontally adjacent pixels
	typedef struct packed {
		logic [8:0] blue;
		logic [8:0] green;
		logic [8:0] red;
	} pair_sum_t;

	// result item, luma in the lowest bits
	typedef struct packed {
		logic [1:0]       pad;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] column;
		logic [7:0]       v_value;
		logic [7:0]       u_value;
		logic [7:0]       luma;
	} out_data_t;

endpackage

`default_nettype wire

FILE: hdl/rgb_to_yuv420_converter.sv
// ---------------------------------------------------------------------------
// rgb_to_yuv420_converter
// RGB pixel stream in, luma per pixel and subsampled U/V per 2x2 block out.
// ---------------------------------------------------------------------------
// Usage
//   s_axis: one RGB pixel per item in raster order, any row flip already done
//   by the source. tdata holds red, green, blue from bit 0 up.
//   m_axis: one result item per pixel. tdata holds luma, u, v, column, row;
//   tuser flags a valid chroma pair (odd row, odd column); tlast marks the
//   last pixel of the frame.
//   cfg: width_pairs (index 0) and height_pairs (index 1), written only
//   while no item is in flight; cfg_ready is always high.
// Timing
//   the block takes one pixel per clock while no result waits stalled on m_axis:
//   each item does at most one line store access on its way in (odd columns
//   only: a write on even rows, a read on odd rows), and the four-stage
//   pipeline behind it holds one item per stage.
// Reset and stall
//   reset empties the pipeline, sets the sizes to 320 x 240 pairs and puts
//   the counters at the first pixel; the line store is not cleared, each
//   entry is written by an even row before the row below reads it.
//   when m_axis_tready is low with a result waiting, the whole pipeline and
//   s_axis_tready hold until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_to_yuv420_converter
	import ryc_pkg::*;
#(
	parameter int MAX_WIDTH      = 2048,
	parameter int MAX_HEIGHT     = 2048,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// red, green, blue (8 bits each)
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// luma, u_value, v_value (8 bits each), column, row (11 bits each), pad
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// chroma_valid
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LINE_PAIRS = MAX_WIDTH / 2;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int AW = (LINE_PAIRS > 1) ? $clog2(LINE_PAIRS) : 1;
	localparam int LWC = ((CW > CFG_DATA_W) ? CW : CFG_DATA_W) + 1;
	localparam int LWR = ((RW > CFG_DATA_W) ? RW : CFG_DATA_W) + 1;
	localparam int CF = COEF_FRAC_BITS;
	localparam int PW = CF + 8;
	localparam int SW = PW + 2;

	localparam logic [LWC-1:0] WP_MAX = LWC'(MAX_WIDTH / 2);
	localparam logic [LWR-1:0] HP_MAX = LWR'(MAX_HEIGHT / 2);

	// rounded coefficients, unsigned Q0.CF
	localparam longint unsigned HALF = COEF_SCALE / 2;
	localparam logic [CF-1:0] Y_R_C = CF'(((Y_R_K << CF) + HALF) / COEF_SCALE);
	localparam logic [CF-1:0] Y_G_C = CF'(((Y_G_K << CF) + HALF) / COEF_SCALE);
	localparam logic [CF-1:0] Y_B_C = CF'(((Y_B_K << CF) + HALF) / COEF_SCALE);
	localparam logic [CF-1:0] U_R_C = CF'(((U_R_K << CF) + HALF) / COEF_SCALE);
	localparam logic [CF-1:0] U_G_C = CF'(((U_G_K << CF) + HALF) / COEF_SCALE);
	localparam logic [CF-1:0] U_B_C = CF'(((U_B_K << CF) + HALF) / COEF_SCALE);
	localparam logic [CF-1:0] V_R_C = CF'(((V_R_K << CF) + HALF) / COEF_SCALE);
	localparam logic [CF-1:0] V_G_C = CF'(((V_G_K << CF) + HALF) / COEF_SCALE);
	localparam logic [CF-1:0] V_B_C = CF'(((V_B_K << CF) + HALF) / COEF_SCALE);

	localparam logic [SW-1:0] TRUNC_BIAS = {{(SW - CF){1'b0}}, {CF{1'b1}}};

	// truncate toward zero, add offset, clip to a byte
	function automatic logic [7:0] chroma_byte(input logic [SW-1:0] s);
		logic [SW-1:0]    adj;
		logic [SW-1:0]    q;
		logic signed [10:0] t;
		adj = s + (s[SW-1] ? TRUNC_BIAS : '0);
		q = SW'($signed(adj) >>> CF);
		t = $signed(q[10:0]) + 11'sd128;
		if (t < 0) begin
			chroma_byte = 8'd0;
		end else if (t > 11'sd255) begin
			chroma_byte = 8'd255;
		end else begin
			chroma_byte = t[7:0];
		end
	endfunction

	logic [CFG_DATA_W-1:0] width_pairs_q;
	logic [CFG_DATA_W-1:0] height_pairs_q;
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	pixel_t                prev_q;

	logic      adv;
	logic      accept;
	pixel_t    pix;
	pair_sum_t psum;
	logic      last_col;
	logic      last_row;
	logic      chroma;
	logic [AW-1:0] idx;
	logic [CW-1:0] half_col;
	logic [LWC-1:0] wp_ext, wp_eff;
	logic [LWR-1:0] hp_ext, hp_eff;
	logic [LWC:0]   col_lim;
	logic [LWR:0]   row_lim;
	logic [CW+POS_W-1:0] col_ext;
	logic [RW+POS_W-1:0] row_ext;
	pair_sum_t rd_sum;

	// stage registers
	logic v_s1, v_s2, v_s3, out_valid_q;
	pixel_t    pix_s1;
	pair_sum_t psum_s1;
	logic      chroma_s1, chroma_s2, chroma_s3, chroma_q;
	logic [POS_W-1:0] col_s1, col_s2, col_s3, col_out_q;
	logic [POS_W-1:0] row_s1, row_s2, row_s3, row_out_q;
	logic      fend_s1, fend_s2, fend_s3, fend_q;
	logic [PW-1:0] y_r_s2, y_g_s2, y_b_s2;
	logic [7:0]    avg_r_s2, avg_g_s2, avg_b_s2;
	logic [7:0]    luma_s3, luma_q;
	logic [PW-1:0] u_r_s3, u_g_s3, u_b_s3, v_r_s3, v_g_s3, v_b_s3;
	logic [7:0]    u_q, v_q;

	logic [PW+1:0] y_sum;
	logic [9:0]    sum_r, sum_g, sum_b;
	logic [SW-1:0] u_sum, v_sum;
	out_data_t     od;

	// handshakes
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign cfg_ready     = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_pairs_q  <= WIDTH_PAIRS_RESET;
			height_pairs_q <= HEIGHT_PAIRS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH_PAIRS: begin
					width_pairs_q <= cfg_data;
				end
				REG_HEIGHT_PAIRS: begin
					height_pairs_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// effective sizes and last column / row limits
	always_comb begin
		wp_ext = LWC'(width_pairs_q);
		hp_ext = LWR'(height_pairs_q);
		if (wp_ext == '0) begin
			wp_eff = LWC'(1);
		end else if (wp_ext > WP_MAX) begin
			wp_eff = WP_MAX;
		end else begin
			wp_eff = wp_ext;
		end
		if (hp_ext == '0) begin
			hp_eff = LWR'(1);
		end else if (hp_ext > HP_MAX) begin
			hp_eff = HP_MAX;
		end else begin
			hp_eff = hp_ext;
		end
		col_lim  = {wp_eff - LWC'(1), 1'b1};
		row_lim  = {hp_eff - LWR'(1), 1'b1};
		last_col = (LWC'(col_q) + {(LWC+1){1'b0}}) >= col_lim;
		last_row = (LWR'(row_q) + {(LWR+1){1'b0}}) >= row_lim;
	end

	// pair sums and line store addressing
	assign pix      = pixel_t'(s_axis_tdata);
	assign chroma   = col_q[0] && row_q[0];
	assign half_col = col_q >> 1;
	assign idx      = half_col[AW-1:0];
	assign psum.red   = {1'b0, prev_q.red} + {1'b0, pix.red};
	assign psum.green = {1'b0, prev_q.green} + {1'b0, pix.green};
	assign psum.blue  = {1'b0, prev_q.blue} + {1'b0, pix.blue};
	assign col_ext  = (CW + POS_W)'(col_q);
	assign row_ext  = (RW + POS_W)'(row_q);

	// even rows write the sums that the odd row below reads; the write
	// always lands a full row before the read, so no forwarding is needed
	ryc_line_store #(
		.DEPTH (LINE_PAIRS),
		.AW    (AW)
	) u_line_store (
		.clk     (clk),
		.wr_en   (accept && col_q[0] && !row_q[0]),
		.wr_addr (idx),
		.wr_data (psum),
		.rd_en   (accept && chroma),
		.rd_addr (idx),
		.rd_data (rd_sum)
	);

	// raster counters and last even-column pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			prev_q <= '0;
		end else if (accept) begin
			if (!col_q[0]) begin
				prev_q <= pix;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// stage 1: capture pixel, sums and position
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1    <= pix;
			psum_s1   <= psum;
			chroma_s1 <= chroma;
			col_s1    <= col_ext[POS_W-1:0];
			row_s1    <= row_ext[POS_W-1:0];
			fend_s1   <= last_col && last_row;
		end
	end

	// block sums with the row above
	assign sum_r = {1'b0, psum_s1.red} + {1'b0, rd_sum.red};
	assign sum_g = {1'b0, psum_s1.green} + {1'b0, rd_sum.green};
	assign sum_b = {1'b0, psum_s1.blue} + {1'b0, rd_sum.blue};

	// stage 2: luma products, block averages
	always_ff @(posedge clk) begin
		if (adv) begin
			y_r_s2    <= PW'(pix_s1.red) * PW'(Y_R_C);
			y_g_s2    <= PW'(pix_s1.green) * PW'(Y_G_C);
			y_b_s2    <= PW'(pix_s1.blue) * PW'(Y_B_C);
			avg_r_s2  <= sum_r[9:2];
			avg_g_s2  <= sum_g[9:2];
			avg_b_s2  <= sum_b[9:2];
			chroma_s2 <= chroma_s1;
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			fend_s2   <= fend_s1;
		end
	end

	assign y_sum = (PW + 2)'(y_r_s2) + (PW + 2)'(y_g_s2) + (PW + 2)'(y_b_s2);

	// stage 3: luma clip, chroma products
	always_ff @(posedge clk) begin
		if (adv) begin
			luma_s3   <= (y_sum[PW+1:CF] > 10'd255) ? 8'd255 : y_sum[CF+7:CF];
			u_r_s3    <= PW'(avg_r_s2) * PW'(U_R_C);
			u_g_s3    <= PW'(avg_g_s2) * PW'(U_G_C);
			u_b_s3    <= PW'(avg_b_s2) * PW'(U_B_C);
			v_r_s3    <= PW'(avg_r_s2) * PW'(V_R_C);
			v_g_s3    <= PW'(avg_g_s2) * PW'(V_G_C);
			v_b_s3    <= PW'(avg_b_s2) * PW'(V_B_C);
			chroma_s3 <= chroma_s2;
			col_s3    <= col_s2;
			row_s3    <= row_s2;
			fend_s3   <= fend_s2;
		end
	end

	// signed chroma sums
	assign u_sum = SW'(u_b_s3) - SW'(u_r_s3) - SW'(u_g_s3);
	assign v_sum = SW'(v_r_s3) - SW'(v_g_s3) - SW'(v_b_s3);

	// output register: chroma offset and clip
	always_ff @(posedge clk) begin
		if (adv) begin
			luma_q    <= luma_s3;
			u_q       <= chroma_s3 ? chroma_byte(u_sum) : 8'd0;
			v_q       <= chroma_s3 ? chroma_byte(v_sum) : 8'd0;
			chroma_q  <= chroma_s3;
			col_out_q <= col_s3;
			row_out_q <= row_s3;
			fend_q    <= fend_s3;
		end
	end

	// result packing
	always_comb begin
		od.pad     = '0;
		od.row     = row_out_q;
		od.column  = col_out_q;
		od.v_value = v_q;
		od.u_value = u_q;
		od.luma    = luma_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = od;
	assign m_axis_tuser  = chroma_q;
	assign m_axis_tlast  = fend_q;

endmodule

`default_nettype wire

FILE: hdl/ryc_line_store.sv
// ---------------------------------------------------------------------------
// ryc_line_store
// One-row store of pair sums: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module ryc_line_store
	import ryc_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire pair_sum_t     wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output pair_sum_t          rd_data
);

	pair_sum_t mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ryc_checker.sv
// ---------------------------------------------------------------------------
// ryc_checker
// Port-level checks of the converter, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ryc_checker
	import ryc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tuser,
	input wire logic                  m_axis_tlast
);

	out_data_t od;

	assign od = out_data_t'(m_axis_tdata);

	// a stalled result item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result item changed while stalled");

	// an empty output stage never back-pressures the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready with empty output stage");

	// no chroma pair means zero u and v
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> od.u_value == 8'd0 && od.v_value == 8'd0)
		else $error("u or v non-zero without chroma pair");

	// chroma pairs only on odd rows at odd columns
	a_chroma_place: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> od.column[0] && od.row[0])
		else $error("chroma pair at even row or column");

endmodule

bind rgb_to_yuv420_converter ryc_checker u_ryc_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_yuv420_converter. Directed frames of
// colour blocks come first, then random pixels over a series of
// image sizes, including zero, oversize and mid-frame size changes. Each
// result is compared with an in-bench model of the conversion, or with fixed
// values for the first directed pixels. The stream sides idle and stall at
// random, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------

module tb;
	import ryc_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 7;
	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 2048;
	localparam int FRAC_BITS    = 16;
	localparam int LINE_PAIRS   = MAX_WIDTH / 2;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int NUM_PHASES   = 13;
	localparam int HOLD_CYCLES  = 150;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} pace_t;

	typedef struct packed {
		logic [7:0]       luma;
		logic             chroma_valid;
		logic [7:0]       u_value;
		logic [7:0]       v_value;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             frame_end;
	} yuv_result_t;

	typedef struct packed {
		pixel_t      px;
		logic        known;
		yuv_result_t want;
	} stim_row_t;

	// fixed-point coefficient, rounded to nearest
	function automatic longint fixed_coef(input longint unsigned k);
		return longint'(((k << FRAC_BITS) + COEF_SCALE / 2) / COEF_SCALE);
	endfunction

	localparam longint YR = fixed_coef(Y_R_K);
	localparam longint YG = fixed_coef(Y_G_K);
	localparam longint YB = fixed_coef(Y_B_K);
	localparam longint UR = -fixed_coef(U_R_K);
	localparam longint UG = -fixed_coef(U_G_K);
	localparam longint UB = fixed_coef(U_B_K);
	localparam longint VR = fixed_coef(V_R_K);
	localparam longint VG = -fixed_coef(V_G_K);
	localparam longint VB = -fixed_coef(V_B_K);

	logic clk = 1'b0;
	logic arst_n;

	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// model state
	logic [CFG_DATA_W-1:0] width_pairs_cfg  = WIDTH_PAIRS_RESET;
	logic [CFG_DATA_W-1:0] height_pairs_cfg = HEIGHT_PAIRS_RESET;
	logic [POS_W-1:0]      col_cnt = '0;
	logic [POS_W-1:0]      row_cnt = '0;
	pixel_t                even_pixel = '0;
	pair_sum_t             pair_line [LINE_PAIRS];
	bit                    line_written [LINE_PAIRS];

	stim_row_t   directed_rows [$];
	stim_row_t   offered_rows [$];
	yuv_result_t pending_yuv [$];

	int error_count = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;

	rgb_to_yuv420_converter #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.COEF_FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rgb_to_yuv420_converter verification failed");
			$finish;
		end
	end

	// size register as the block sees it
	function automatic int eff_pairs(input logic [CFG_DATA_W-1:0] v, input int maxv);
		if (v == 0) return 1;
		return (int'(v) > maxv) ? maxv : int'(v);
	endfunction

	function automatic logic [7:0] clip_byte(input longint v);
		if (v < 0) return 8'd0;
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// chroma: truncate toward zero, add offset, clip
	function automatic logic [7:0] chroma_of(input longint kr, input longint kg,
			input longint kb, input longint r, input longint g, input longint b);
		longint s;
		longint t;
		s = kr * r + kg * g + kb * b;
		t = (s >= 0) ? (s >>> FRAC_BITS) : -((-s) >>> FRAC_BITS);
		return clip_byte(t + CHROMA_OFFSET);
	endfunction

	// one pixel through the conversion, advancing the counters and line store
	task automatic convert_pixel(input pixel_t px, output yuv_result_t res);
		int        w;
		int        h;
		int        idx;
		bit        last_col;
		bit        last_row;
		longint    r;
		longint    g;
		longint    b;
		longint    ar;
		longint    ag;
		longint    ab;
		pair_sum_t here;
		pair_sum_t above;
		w = 2 * eff_pairs(width_pairs_cfg, MAX_WIDTH / 2);
		h = 2 * eff_pairs(height_pairs_cfg, MAX_HEIGHT / 2);
		last_col = int'(col_cnt) >= w - 1;
		last_row = int'(row_cnt) >= h - 1;
		idx = int'(col_cnt) >> 1;
		r = px.red;
		g = px.green;
		b = px.blue;
		res = '0;
		res.luma = clip_byte((YR * r + YG * g + YB * b) >>> FRAC_BITS);
		if (!col_cnt[0]) begin
			even_pixel = px;
		end else begin
			here.red   = 9'(even_pixel.red) + 9'(px.red);
			here.green = 9'(even_pixel.green) + 9'(px.green);
			here.blue  = 9'(even_pixel.blue) + 9'(px.blue);
			if (!row_cnt[0]) begin
				pair_line[idx] = here;
				line_written[idx] = 1'b1;
			end else begin
				above = pair_line[idx];
				ar = (longint'(here.red) + longint'(above.red)) >>> 2;
				ag = (longint'(here.green) + longint'(above.green)) >>> 2;
				ab = (longint'(here.blue) + longint'(above.blue)) >>> 2;
				res.chroma_valid = 1'b1;
				res.u_value = chroma_of(UR, UG, UB, ar, ag, ab);
				res.v_value = chroma_of(VR, VG, VB, ar, ag, ab);
			end
		end
		res.column = col_cnt;
		res.row = row_cnt;
		res.frame_end = last_col && last_row;
		if (last_col) begin
			col_cnt = '0;
			row_cnt = last_row ? '0 : row_cnt + 1'b1;
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
	endtask

	// a new width must never make an odd row read a line entry no even row wrote
	function automatic bit width_safe(input logic [CFG_DATA_W-1:0] wp);
		bit seen [LINE_PAIRS];
		int w;
		int last;
		w = 2 * eff_pairs(wp, MAX_WIDTH / 2);
		last = (int'(col_cnt) >= w - 1) ? int'(col_cnt) : w - 1;
		seen = line_written;
		for (int c = int'(col_cnt); c <= last; c++) begin
			if (c % 2 == 1) begin
				if (row_cnt[0]) begin
					if (!seen[c / 2]) return 1'b0;
				end else begin
					seen[c / 2] = 1'b1;
				end
			end
		end
		if (!row_cnt[0]) begin
			for (int i = 0; i < w / 2; i++)
				if (!seen[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count = error_count + 1;
		end
	endtask

	// predict on accepted pixels, check accepted results
	always @(posedge clk) begin : result_monitor
		yuv_result_t pred;
		yuv_result_t want;
		stim_row_t   offered;
		out_data_t   od;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH_PAIRS:  width_pairs_cfg = cfg_data;
					REG_HEIGHT_PAIRS: height_pairs_cfg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				convert_pixel(pixel_t'(s_axis_tdata), pred);
				offered = offered_rows.pop_front();
				pending_yuv.push_back(offered.known ? offered.want : pred);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				od = out_data_t'(m_axis_tdata);
				if (pending_yuv.size() == 0) begin
					$error("result item with nothing expected");
					error_count = error_count + 1;
				end else begin
					want = pending_yuv.pop_front();
					compare_field("luma", want.luma, od.luma);
					compare_field("chroma_valid", want.chroma_valid, m_axis_tuser);
					compare_field("u_value", want.u_value, od.u_value);
					compare_field("v_value", want.v_value, od.v_value);
					compare_field("column", want.column, od.column);
					compare_field("row", want.row, od.row);
					compare_field("frame_end", want.frame_end, m_axis_tlast);
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic set_pace(input pace_t p);
		case (p)
			IDLE_SENDER:   begin tx_idle_pct = 62; rx_stall_pct = 0;  end
			IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
			IDLE_BOTH:     begin tx_idle_pct = 7;  rx_stall_pct = 7;  end
			default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
		endcase
	endtask

	task automatic add_known(input int r, input int g, input int b, input int luma,
			input int cv, input int u, input int v, input int col, input int row,
			input int fe);
		stim_row_t s;
		s.px = '{blue: 8'(b), green: 8'(g), red: 8'(r)};
		s.known = 1'b1;
		s.want = '{luma: 8'(luma), chroma_valid: 1'(cv), u_value: 8'(u), v_value: 8'(v),
			column: POS_W'(col), row: POS_W'(row), frame_end: 1'(fe)};
		directed_rows.push_back(s);
	endtask

	task automatic add_pixel(input int r, input int g, input int b);
		stim_row_t s;
		s = '0;
		s.px = '{blue: 8'(b), green: 8'(g), red: 8'(r)};
		directed_rows.push_back(s);
	endtask

	function automatic logic [7:0] random_channel();
		case ($urandom_range(7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t s;
		s = '0;
		s.px.red = random_channel();
		s.px.green = random_channel();
		s.px.blue = random_channel();
		return s;
	endfunction

	// offer one pixel, after a random idle gap, until it is taken
	task automatic send_pixel(input stim_row_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		offered_rows.push_back(s);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s.px;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_sizes(input logic [CFG_DATA_W-1:0] wp,
			input logic [CFG_DATA_W-1:0] hp);
		write_reg(REG_WIDTH_PAIRS, wp);
		write_reg(REG_HEIGHT_PAIRS, hp);
		cfg_valid <= 1'b0;
	endtask

	// stop offering and wait for every expected result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_yuv.size() != 0);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] wp;
		logic [CFG_DATA_W-1:0] hp;
		int                    n_items;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WIDTH_PAIRS;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 4x4 frame: white and black blocks, then red and blue blocks
		add_known(255, 255, 255, 255, 0, 0, 0, 0, 0, 0);
		add_known(255, 255, 255, 255, 0, 0, 0, 1, 0, 0);
		add_known(0, 0, 0, 0, 0, 0, 0, 2, 0, 0);
		add_known(0, 0, 0, 0, 0, 0, 0, 3, 0, 0);
		add_known(255, 255, 255, 255, 0, 0, 0, 0, 1, 0);
		add_known(255, 255, 255, 255, 1, 128, 128, 1, 1, 0);
		add_known(0, 0, 0, 0, 0, 0, 0, 2, 1, 0);
		add_known(0, 0, 0, 0, 1, 128, 128, 3, 1, 0);
		add_pixel(255, 0, 0);
		add_pixel(255, 0, 0);
		add_pixel(0, 0, 255);
		add_pixel(0, 0, 255);
		add_pixel(255, 0, 0);
		add_pixel(255, 0, 0);
		add_pixel(0, 0, 255);
		add_pixel(0, 0, 255);
		// next frame: green block clips v low, mixed block
		add_pixel(0, 255, 0);
		add_pixel(0, 255, 0);
		add_pixel(255, 255, 0);
		add_pixel(255, 0, 255);
		add_pixel(0, 255, 0);
		add_pixel(0, 255, 0);
		add_pixel(0, 255, 255);
		add_pixel(128, 128, 128);

		set_pace(IDLE_NONE);
		write_sizes(11'd2, 11'd2);
		foreach (directed_rows[i]) send_pixel(directed_rows[i]);
		drain_results();

		// random phases: extreme sizes first, then small random sizes
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       begin wp = 11'd1;    hp = 11'd1;    n_items = 60;  end
				1:       begin wp = 11'd0;    hp = 11'd0;    n_items = 30;  end
				2:       begin wp = 11'd2047; hp = 11'd1024; n_items = 120; end
				3:       begin wp = 11'd1024; hp = 11'd2047; n_items = 60;  end
				default: begin
					wp = 11'($urandom_range(8));
					hp = 11'($urandom_range(5));
					n_items = 65;
				end
			endcase
			if (!width_safe(wp)) wp = width_pairs_cfg;
			write_sizes(wp, hp);
			set_pace(pace_t'(ph % 4));
			if (ph == 4) hold_left = HOLD_CYCLES;
			repeat (n_items) send_pixel(random_row());
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_yuv.size() != 0) begin
			$error("%0d expected results never arrived", pending_yuv.size());
			error_count = error_count + 1;
		end
		if (error_count == 0) begin
			$display("rgb_to_yuv420_converter verification clean");
		end else begin
			$display("rgb_to_yuv420_converter verification failed");
		end
		$finish;
	end

endmodule
